// File: sv/timed_release_priority_queue_defines.svh
// assertion macros for the timed release priority queue checker
// no dependencies; included by the checker file
`ifndef TIMED_RELEASE_PRIORITY_QUEUE_DEFINES_SVH
`define TIMED_RELEASE_PRIORITY_QUEUE_DEFINES_SVH

// property checked at every rising edge outside reset
`define TRPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define TRPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/trpq_pkg.sv
// shared types and constants of the timed release priority queue
// no dependencies; imported by the top level and the checker
`default_nettype none

package trpq_pkg;

   localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned TIME_W   = 16;
   localparam int unsigned STATUS_W = 2;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] remaining;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_CMP,
      S_ADD_PUT,
      S_TICK_UPD,
      S_REL_RD,
      S_REL_OUT,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// File: sv/timed_release_priority_queue.sv
// timed release priority queue: sorted ring of pending entries in one memory
// depends on trpq_pkg
//
// usage:
//   req channel (valid/stall) takes one transaction: an add (mode 0) inserts
//   item_id with delay_minutes in ascending order, ties after older entries;
//   a tick (mode 1) subtracts tick_minutes from every entry, saturating at 0,
//   then releases all entries at 0 from the front, in order.
//   rsp channel (valid/stall) gives status, released_id and last. an add
//   gives one response (accepted, or rejected when full). a tick gives one
//   response per released entry, last set on the final one, or none at all.
//   an add steps back from the tail, moving each entry it passes up one place,
//   and then writes the new entry; a tick makes an update pass over all entries
//   through the memory read port, then reads out the entries at 0 from the front
//   and gives one response per released entry.
//   one transaction is worked on at a time; req_stall is low only while idle.
//   an output register holds the response; while rsp_stall is high it holds
//   its payload and the block waits before the next response.
//   reset (synchronous) empties the queue; the memory is not cleared.
`default_nettype none

module timed_release_priority_queue #(
   parameter int unsigned QUEUE_DEPTH = trpq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [trpq_pkg::ID_W-1:0]     req_item_id,
   input  wire logic [trpq_pkg::TIME_W-1:0]   req_delay_minutes,
   input  wire logic [trpq_pkg::TIME_W-1:0]   req_tick_minutes,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [trpq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [trpq_pkg::ID_W-1:0]          rsp_released_id,
   output logic                               rsp_last
);
   import trpq_pkg::*;

   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
   endfunction

   state_type state_ff, state_in;

   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [CNT_W-1:0]    zcnt_ff, zcnt_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TIME_W-1:0]   delay_ff, delay_in;
   logic [TIME_W-1:0]   tick_ff, tick_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_load;

   entry_type           mem [QUEUE_DEPTH];
   entry_type           rd_ff;
   logic                mem_we, mem_re;
   logic [IDX_W-1:0]    mem_waddr, mem_raddr;
   entry_type           mem_wdata;

   logic                accept, full, rsp_free, less, zero_now;
   logic [CNT_W:0]      tail_sum;
   logic [IDX_W-1:0]    tail;
   logic [TIME_W-1:0]   sat;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign tail_sum  = (CNT_W+1)'(front_ff) + (CNT_W+1)'(count_ff);
   assign tail      = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
   assign less      = (delay_ff < rd_ff.remaining);
   assign sat       = (rd_ff.remaining > tick_ff) ? rd_ff.remaining - tick_ff : '0;
   assign zero_now  = (sat == '0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_released_id = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ADD) begin
                  if (full)
                     state_in = S_RESP;
                  else if (count_ff == '0)
                     state_in = S_ADD_PUT;
                  else
                     state_in = S_ADD_CMP;
               end else if (count_ff != '0) begin
                  state_in = S_TICK_UPD;
               end
            end
         end
         S_ADD_CMP: begin
            if (!less)
               state_in = S_RESP;
            else if (left_ff == CNT_W'(1))
               state_in = S_ADD_PUT;
         end
         S_ADD_PUT: state_in = S_RESP;
         S_TICK_UPD: begin
            if (left_ff == CNT_W'(1))
               state_in = ((zcnt_ff != '0) || zero_now) ? S_REL_RD : S_IDLE;
         end
         S_REL_RD: state_in = S_REL_OUT;
         S_REL_OUT: begin
            if (rsp_free && zcnt_ff == CNT_W'(1))
               state_in = S_IDLE;
         end
         S_RESP: begin
            if (rsp_free)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      zcnt_in   = zcnt_ff;
      id_in     = id_ff;
      delay_in  = delay_ff;
      tick_in   = tick_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = pos_ff;
      mem_raddr = front_ff;
      mem_wdata = '{id: id_ff, remaining: delay_ff};
      rsp_load      = 1'b0;
      rsp_status_in = status_ff;
      rsp_id_in     = id_ff;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_in    = req_item_id;
               delay_in = req_delay_minutes;
               tick_in  = req_tick_minutes;
               if (req_mode == MODE_ADD) begin
                  status_in = full ? ST_REJECTED : ST_ACCEPTED;
                  pos_in    = tail;
                  left_in   = count_ff;
                  if (!full && count_ff != '0) begin
                     mem_re    = 1'b1;
                     mem_raddr = ring_prev(tail);
                  end
               end else begin
                  pos_in    = front_ff;
                  left_in   = count_ff;
                  zcnt_in   = '0;
                  mem_re    = (count_ff != '0);
                  mem_raddr = front_ff;
               end
            end
         end
         S_ADD_CMP: begin
            mem_we = 1'b1;
            if (less) begin
               mem_wdata = rd_ff;
               pos_in    = ring_prev(pos_ff);
               left_in   = left_ff - 1'b1;
               if (left_ff != CNT_W'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = ring_prev(ring_prev(pos_ff));
               end
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         S_ADD_PUT: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
         end
         S_TICK_UPD: begin
            mem_we    = 1'b1;
            mem_wdata = '{id: rd_ff.id, remaining: sat};
            zcnt_in   = zcnt_ff + CNT_W'(zero_now);
            pos_in    = ring_next(pos_ff);
            left_in   = left_ff - 1'b1;
            if (left_ff != CNT_W'(1)) begin
               mem_re    = 1'b1;
               mem_raddr = ring_next(pos_ff);
            end
         end
         S_REL_RD: begin
            mem_re = 1'b1;
         end
         S_REL_OUT: begin
            if (rsp_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_RELEASED;
               rsp_id_in     = rd_ff.id;
               rsp_last_in   = (zcnt_ff == CNT_W'(1));
               front_in      = ring_next(front_ff);
               count_in      = count_ff - 1'b1;
               zcnt_in       = zcnt_ff - 1'b1;
               if (zcnt_ff != CNT_W'(1)) begin
                  mem_re    = 1'b1;
                  mem_raddr = ring_next(front_ff);
               end
            end
         end
         S_RESP: begin
            rsp_load = rsp_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      zcnt_ff   <= zcnt_in;
      id_ff     <= id_in;
      delay_ff  <= delay_in;
      tick_ff   <= tick_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // entry store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      if (mem_re)
         rd_ff <= mem[mem_raddr];
   end

endmodule

`default_nettype wire

// File: sv/trpq_checker.sv
// port-level checks of the timed release priority queue, bound to the top level
// depends on trpq_pkg and timed_release_priority_queue_defines.svh
`default_nettype none

`include "timed_release_priority_queue_defines.svh"

module trpq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          req_mode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [trpq_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [trpq_pkg::ID_W-1:0]     rsp_released_id,
   input wire logic                          rsp_last
);
   import trpq_pkg::*;

   `TRPQ_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_released_id) && $stable(rsp_last)),
      "stalled response changed")
   `TRPQ_ASSERT(a_status_code, clock, reset,
      rsp_valid |-> (rsp_status == ST_RELEASED || rsp_status == ST_ACCEPTED
         || rsp_status == ST_REJECTED),
      "undefined response status")
   `TRPQ_ASSERT(a_add_single, clock, reset,
      (rsp_valid && (rsp_status == ST_ACCEPTED || rsp_status == ST_REJECTED)) |-> rsp_last,
      "add response without last")
   `TRPQ_ASSERT(a_add_busy, clock, reset,
      (req_valid && !req_stall && req_mode == MODE_ADD) |=> req_stall,
      "add transaction did not occupy the block")
   `TRPQ_ASSERT_ALWAYS(a_reset_idle, clock,
      ($past(reset) && !reset) |-> (!rsp_valid && !req_stall),
      "block not idle after reset")

endmodule

bind timed_release_priority_queue trpq_checker u_trpq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_released_id (rsp_released_id),
   .rsp_last        (rsp_last)
);

`default_nettype wire
